### rtl/core/sie_pkg.sv
// ----------------------------------------------------------------------------
// sie_pkg
// Shared types, widths and codes of the sample interval estimator.
// ----------------------------------------------------------------------------
package sie_pkg;

  // Table and field sizes
  localparam int NumBins = 15;
  localparam int BinIdxW = $clog2(NumBins);
  localparam int TimeW   = 48;
  localparam int CntW    = 32;
  localparam int TolW    = 20;

  // Divider sizes: numerator 2*span+interval, denominator 2*interval
  localparam int DivNumW = TimeW + 2;
  localparam int DivDenW = CntW + 1;
  localparam int DivCntW = $clog2(DivNumW);

  // Input action codes
  localparam logic [1:0] ActEpoch  = 2'd0;
  localparam logic [1:0] ActReport = 2'd1;
  localparam logic [1:0] ActClear  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] RegWinBegin  = 2'd0;
  localparam logic [1:0] RegWinEnd    = 2'd1;
  localparam logic [1:0] RegTolerance = 2'd2;

  // Result status codes
  localparam logic [2:0] StCounted    = 3'd0;
  localparam logic [2:0] StBefore     = 3'd1;
  localparam logic [2:0] StStopped    = 3'd2;
  localparam logic [2:0] StHeader     = 3'd3;
  localparam logic [2:0] StOutOfOrder = 3'd4;
  localparam logic [2:0] StReport     = 3'd5;
  localparam logic [2:0] StCleared    = 3'd6;

  // Result payload, first field in the highest bits
  typedef struct packed {
    logic [TimeW-1:0] possible_epochs;
    logic [TimeW-1:0] last_time;
    logic [TimeW-1:0] first_time;
    logic [CntW-1:0]  header_block_count;
    logic [CntW-1:0]  epoch_count;
    logic [CntW-1:0]  interval;
  } res_data_t;

  typedef struct packed {
    logic       interval_valid;
    logic [2:0] status;
  } res_user_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Saturating increment of a count
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (&v) ? v : v + CntW'(1);
  endfunction

endpackage

### rtl/core/sie_div.sv
// ----------------------------------------------------------------------------
// sie_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sie_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sie_pkg::DivNumW-1:0] numer_i,
  input  logic [sie_pkg::DivDenW-1:0] denom_i,
  output logic [sie_pkg::DivNumW-1:0] quot_o,
  output sie_pkg::div_stat_t          stat_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [sie_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [sie_pkg::DivDenW-1:0] rem_q, rem_d;
  logic [sie_pkg::DivDenW-1:0] den_q, den_d;
  logic [sie_pkg::DivNumW-1:0] quot_q, quot_d;
  logic [sie_pkg::DivDenW:0]   trial;
  logic                        fits;

  // Shift the next numerator bit into the partial remainder
  assign trial = {rem_q, quot_q[sie_pkg::DivNumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = sie_pkg::DivCntW'(sie_pkg::DivNumW - 1);
      rem_d  = '0;
      den_d  = denom_i;
      quot_d = numer_i;
    end else if (busy_q) begin
      rem_d  = fits ? sie_pkg::DivDenW'(trial - {1'b0, den_q})
                    : trial[sie_pkg::DivDenW-1:0];
      quot_d = {quot_q[sie_pkg::DivNumW-2:0], fits};
      cnt_d  = cnt_q - sie_pkg::DivCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath holds no reset
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### rtl/core/sample_interval_estimator.sv
// An epoch item may walk the bins for a matching or an empty bin, and then walk them
//   again for the least-count bin to replace; a clear or dropped item walks no bins.
// A report walks the bins for the most frequent one, then, unless the table is empty, runs
//   the one-bit-per-cycle divider for the possible epoch count.
// One item is in work at a time; s_axis_tready is high only while idle.
// Reset (rst_ni low, asynchronous) empties bins, counts and times, and loads defaults.
// ----------------------------------------------------------------------------
// sample_interval_estimator
// Dominant interval finder over a stream of epoch time stamps, with a
// small table of interval bins walked by a sequencer.
// ----------------------------------------------------------------------------
module sample_interval_estimator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration writes
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [sie_pkg::TimeW-1:0] cfg_wdata_i,
  // Input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [47:0]               s_axis_tdata,  // epoch_time[47:0]
  input  logic [4:0]                s_axis_tuser,  // action[1:0], epoch_flag[4:2]
  // Result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // interval[31:0], epoch_count[63:32], header_block_count[95:64],
  // first_time[143:96], last_time[191:144], possible_epochs[239:192]
  output logic [239:0]              m_axis_tdata,
  output logic [3:0]                m_axis_tuser   // status[2:0], interval_valid[3]
);

  localparam int TW = sie_pkg::TimeW;
  localparam int CW = sie_pkg::CntW;
  localparam int IW = sie_pkg::BinIdxW;
  localparam logic [IW-1:0] LastIdx = IW'(sie_pkg::NumBins - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EVAL  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_MIN   = 8'b0000_1000,
    S_RMAX  = 8'b0001_0000,
    S_RSPAN = 8'b0010_0000,
    S_RDIV  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [TW-1:0]               win_begin_q, win_end_q;
  logic [sie_pkg::TolW-1:0]    tol_q;

  // Tracking state
  logic [TW-1:0] prev_time_q, prev_time_d;
  logic          have_prev_q, have_prev_d;
  logic [TW-1:0] first_time_q, first_time_d;
  logic          have_first_q, have_first_d;
  logic [TW-1:0] last_time_q, last_time_d;
  logic [CW-1:0] counted_q, counted_d;
  logic [CW-1:0] headers_q, headers_d;
  logic          stopped_q, stopped_d;

  // Bin table
  logic [CW-1:0] bin_interval_q [sie_pkg::NumBins];
  logic [CW-1:0] bin_count_q    [sie_pkg::NumBins];
  logic          cnt_we, iv_we, clr_bins;
  logic [IW-1:0] wr_idx;
  logic [CW-1:0] cnt_wdata;

  // Captured item and walk registers
  logic [1:0]    action_q;
  logic [TW-1:0] time_q;
  logic [2:0]    flag_q;
  logic [CW-1:0] dt_q, dt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] sel_q, sel_d;
  logic [TW-1:0] span_q, span_d;
  logic [CW-1:0] iv_q, iv_d;
  logic          div_go_q, div_go_d;

  // Pending result and output register
  sie_pkg::res_data_t res_data_q, res_data_d, out_data_q;
  sie_pkg::res_user_t res_user_q, res_user_d, out_user_q;
  logic               m_valid_q, m_valid_d;
  logic               out_load;

  // Divider
  logic [sie_pkg::DivNumW-1:0] div_numer;
  logic [sie_pkg::DivDenW-1:0] div_denom;
  logic [sie_pkg::DivNumW-1:0] div_quot;
  sie_pkg::div_stat_t          div_stat;
  logic [sie_pkg::DivNumW:0]   pe_sum;

  // Walk helpers
  logic [CW-1:0] cur_cnt, cur_iv, abs_diff, sel_cnt;
  logic          tol_match, min_le, max_gt;
  logic [IW-1:0] min_next, max_next;
  logic [TW-1:0] delta;

  logic s_accept;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // Bin at the walk index against the current delta
  assign cur_cnt   = bin_count_q[idx_q];
  assign cur_iv    = bin_interval_q[idx_q];
  assign sel_cnt   = bin_count_q[sel_q];
  assign abs_diff  = (dt_q > cur_iv) ? dt_q - cur_iv : cur_iv - dt_q;
  assign tol_match = abs_diff < CW'(tol_q);
  assign min_le    = cur_cnt <= sel_cnt;
  assign min_next  = min_le ? idx_q : sel_q;
  assign max_gt    = cur_cnt > sel_cnt;
  assign max_next  = max_gt ? idx_q : sel_q;
  assign delta     = time_q - prev_time_q;

  // Divider operands: (2*span + interval) / (2*interval)
  assign div_numer = {1'b0, span_q, 1'b0} + sie_pkg::DivNumW'(iv_q);
  assign div_denom = {iv_q, 1'b0};
  assign pe_sum    = {1'b0, div_quot} + (sie_pkg::DivNumW + 1)'(1);

  // Result register takes the pending result when the slot is free
  assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    prev_time_d  = prev_time_q;
    have_prev_d  = have_prev_q;
    first_time_d = first_time_q;
    have_first_d = have_first_q;
    last_time_d  = last_time_q;
    counted_d    = counted_q;
    headers_d    = headers_q;
    stopped_d    = stopped_q;
    dt_d         = dt_q;
    idx_d        = idx_q;
    sel_d        = sel_q;
    span_d       = span_q;
    iv_d         = iv_q;
    div_go_d     = 1'b0;
    res_data_d   = res_data_q;
    res_user_d   = res_user_q;
    cnt_we       = 1'b0;
    iv_we        = 1'b0;
    clr_bins     = 1'b0;
    wr_idx       = idx_q;
    cnt_wdata    = CW'(1);

    case (state_q)
      S_IDLE: begin
        if (s_accept) state_d = S_EVAL;
      end

      // Dispatch the captured item
      S_EVAL: begin
        res_data_d = '0;
        res_user_d = '0;
        state_d    = S_DONE;
        case (action_q)
          sie_pkg::ActEpoch: begin
            if (stopped_q) begin
              res_user_d.status = sie_pkg::StStopped;
            end else if (flag_q > 3'd1) begin
              headers_d         = sie_pkg::sat_inc(headers_q);
              res_user_d.status = sie_pkg::StHeader;
            end else begin
              last_time_d = time_q;
              if (time_q < win_begin_q) begin
                res_user_d.status = sie_pkg::StBefore;
              end else if (time_q > win_end_q) begin
                stopped_d         = 1'b1;
                res_user_d.status = sie_pkg::StStopped;
              end else begin
                if (!have_first_q) begin
                  first_time_d = time_q;
                  have_first_d = 1'b1;
                end
                counted_d         = sie_pkg::sat_inc(counted_q);
                prev_time_d       = time_q;
                have_prev_d       = 1'b1;
                res_user_d.status = sie_pkg::StCounted;
                if (have_prev_q) begin
                  if (time_q > prev_time_q) begin
                    dt_d    = (|delta[TW-1:CW]) ? '1 : delta[CW-1:0];
                    idx_d   = '0;
                    state_d = S_SCAN;
                  end else begin
                    res_user_d.status = sie_pkg::StOutOfOrder;
                  end
                end
              end
            end
          end
          sie_pkg::ActReport: begin
            res_user_d.status             = sie_pkg::StReport;
            res_data_d.epoch_count        = counted_q;
            res_data_d.header_block_count = headers_q;
            res_data_d.first_time         = first_time_q;
            res_data_d.last_time          = last_time_q;
            sel_d                         = '0;
            idx_d                         = IW'(1);
            state_d                       = S_RMAX;
          end
          sie_pkg::ActClear: begin
            clr_bins          = 1'b1;
            prev_time_d       = '0;
            have_prev_d       = 1'b0;
            first_time_d      = '0;
            have_first_d      = 1'b0;
            last_time_d       = '0;
            counted_d         = '0;
            headers_d         = '0;
            stopped_d         = 1'b0;
            res_user_d.status = sie_pkg::StCleared;
          end
          default: begin
            // Unused action: drop without a result
            state_d = S_IDLE;
          end
        endcase
      end

      // Walk for a matching or an empty bin
      S_SCAN: begin
        if (cur_cnt == '0) begin
          cnt_we  = 1'b1;
          iv_we   = 1'b1;
          state_d = S_DONE;
        end else if (tol_match) begin
          cnt_we    = 1'b1;
          cnt_wdata = sie_pkg::sat_inc(cur_cnt);
          state_d   = S_DONE;
        end else if (idx_q == LastIdx) begin
          idx_d   = IW'(1);
          sel_d   = '0;
          state_d = S_MIN;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      // Walk for the least-count bin, last tie wins, then replace it
      S_MIN: begin
        if (idx_q == LastIdx) begin
          wr_idx  = min_next;
          cnt_we  = 1'b1;
          iv_we   = 1'b1;
          state_d = S_DONE;
        end else begin
          sel_d = min_next;
          idx_d = idx_q + IW'(1);
        end
      end

      // Walk for the most frequent bin, first maximum wins
      S_RMAX: begin
        sel_d = max_next;
        if (idx_q == LastIdx) begin
          state_d = (bin_count_q[max_next] != '0) ? S_RSPAN : S_DONE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      // Take the interval and the span, then start the divide
      S_RSPAN: begin
        iv_d                      = bin_interval_q[sel_q];
        span_d                    = (last_time_q >= first_time_q)
                                    ? last_time_q - first_time_q : '0;
        res_data_d.interval       = bin_interval_q[sel_q];
        res_user_d.interval_valid = 1'b1;
        div_go_d                  = 1'b1;
        state_d                   = S_RDIV;
      end

      // Wait for the quotient and saturate the epoch count
      S_RDIV: begin
        if (div_stat.done) begin
          res_data_d.possible_epochs = (|pe_sum[sie_pkg::DivNumW:TW])
                                       ? '1 : pe_sum[TW-1:0];
          state_d                    = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop once the result is taken
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // Control and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      win_begin_q  <= '0;
      win_end_q    <= '1;
      tol_q        <= sie_pkg::TolW'(100);
      prev_time_q  <= '0;
      have_prev_q  <= 1'b0;
      first_time_q <= '0;
      have_first_q <= 1'b0;
      last_time_q  <= '0;
      counted_q    <= '0;
      headers_q    <= '0;
      stopped_q    <= 1'b0;
      idx_q        <= '0;
      sel_q        <= '0;
      div_go_q     <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_time_q  <= prev_time_d;
      have_prev_q  <= have_prev_d;
      first_time_q <= first_time_d;
      have_first_q <= have_first_d;
      last_time_q  <= last_time_d;
      counted_q    <= counted_d;
      headers_q    <= headers_d;
      stopped_q    <= stopped_d;
      idx_q        <= idx_d;
      sel_q        <= sel_d;
      div_go_q     <= div_go_d;
      m_valid_q    <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sie_pkg::RegWinBegin:  win_begin_q <= cfg_wdata_i;
          sie_pkg::RegWinEnd:    win_end_q   <= cfg_wdata_i;
          sie_pkg::RegTolerance: tol_q       <= cfg_wdata_i[sie_pkg::TolW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Bin counts: zero marks an empty bin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sie_pkg::NumBins; i++) bin_count_q[i] <= '0;
    end else if (clr_bins) begin
      for (int i = 0; i < sie_pkg::NumBins; i++) bin_count_q[i] <= '0;
    end else if (cnt_we) begin
      bin_count_q[wr_idx] <= cnt_wdata;
    end
  end

  // Bin intervals are written with their count and need no reset
  always_ff @(posedge clk_i) begin
    if (iv_we) bin_interval_q[wr_idx] <= dt_q;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      action_q <= s_axis_tuser[1:0];
      flag_q   <= s_axis_tuser[4:2];
      time_q   <= s_axis_tdata;
    end
    dt_q       <= dt_d;
    span_q     <= span_d;
    iv_q       <= iv_d;
    res_data_q <= res_data_d;
    res_user_q <= res_user_d;
    if (out_load) begin
      out_data_q <= res_data_q;
      out_user_q <= res_user_q;
    end
  end

  sie_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .numer_i (div_numer),
    .denom_i (div_denom),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### rtl/core/sie_checker.sv
// ----------------------------------------------------------------------------
// sie_checker
// Port-level checks on the sample interval estimator, bound to the top.
// ----------------------------------------------------------------------------
module sie_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [239:0] m_axis_tdata,
  input logic [3:0]   m_axis_tuser
);

  // A stalled result holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // An accepted item keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again straight after a transfer");

  // A valid interval comes only with a report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == sie_pkg::StReport)
    else $error("interval flagged valid outside a report");

  // Results other than a report carry an all-zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:0] != sie_pkg::StReport)
      |-> m_axis_tdata == '0 && !m_axis_tuser[3])
    else $error("non-report result carries data");

  // Status never takes the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[2:0] != 3'd7)
    else $error("unused status code on output");

endmodule

bind sample_interval_estimator sie_checker u_sie_checker (.*);
